@@ rtl/i2cms_pkg.sv @@
// Shared types and constants for the I2C master register sequencer.
// Depends on nothing; the stage, core and top files in rtl import it.

package i2cms_pkg;

	// Longest read burst; the request count is clamped to it
	localparam int MAX_BURST = 255;

	// Configuration register indexes
	localparam logic CFG_TIMEOUT_MS = 1'b0;
	localparam logic CFG_BUSY_RETRY = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0] TIMEOUT_MS_RST = 8'd5;
	localparam logic [7:0] BUSY_RETRY_RST = 8'd100;

	// Event codes of an input word
	localparam logic [2:0] REQ_READ    = 3'd0;
	localparam logic [2:0] REQ_WRITE   = 3'd1;
	localparam logic [2:0] REQ_BUSY    = 3'd2;
	localparam logic [2:0] REQ_BYTE_DN = 3'd3;
	localparam logic [2:0] REQ_MS_TICK = 3'd4;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_SEND    = 3'd2,
		ACT_RESTART = 3'd3,
		ACT_RXACK   = 3'd4,
		ACT_RXNACK  = 3'd5,
		ACT_STOP    = 3'd6
	} act_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_BUSY = 3'd1,
		ST_TMO  = 3'd2,
		ST_ARB  = 3'd3,
		ST_NACK = 3'd4
	} status_t;

	typedef enum logic [9:0] {
		PH_IDLE  = 10'b00_0000_0001,
		PH_BUSY  = 10'b00_0000_0010,
		PH_RADDR = 10'b00_0000_0100,
		PH_RPTR  = 10'b00_0000_1000,
		PH_RREAD = 10'b00_0001_0000,
		PH_RDATA = 10'b00_0010_0000,
		PH_WADDR = 10'b00_0100_0000,
		PH_WREG  = 10'b00_1000_0000,
		PH_WHI   = 10'b01_0000_0000,
		PH_WLO   = 10'b10_0000_0000
	} phase_t;

	// One input word
	typedef struct packed {
		logic [2:0]  req_type;
		logic [6:0]  slave_addr;
		logic [7:0]  reg_addr;
		logic [7:0]  byte_count;
		logic [15:0] write_value;
		logic        bus_busy;
		logic        nack_seen;
		logic        arb_lost;
		logic [7:0]  rx_byte;
	} req_t;

	// One result word
	typedef struct packed {
		act_t        bus_action;
		logic [7:0]  tx_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        done_res;
		status_t     status;
		logic [7:0]  bytes_done;
	} res_t;

endpackage

@@ rtl/i2cms_if.sv @@
// Valid/ready channel interfaces for request and result words.
// Depends on nothing beyond plain logic types.

interface i2cms_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [6:0]  slave_addr;
	logic [7:0]  reg_addr;
	logic [7:0]  byte_count;
	logic [15:0] write_value;
	logic        bus_busy;
	logic        nack_seen;
	logic        arb_lost;
	logic [7:0]  rx_byte;

	modport source (
		output valid, req_type, slave_addr, reg_addr, byte_count, write_value,
		       bus_busy, nack_seen, arb_lost, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, slave_addr, reg_addr, byte_count, write_value,
		       bus_busy, nack_seen, arb_lost, rx_byte,
		output ready
	);
endinterface

interface i2cms_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] bus_action;
	logic [7:0] tx_byte;
	logic       data_valid;
	logic [7:0] data_byte;
	logic       done_res;
	logic [2:0] status;
	logic [7:0] bytes_done;

	modport source (
		output valid, bus_action, tx_byte, data_valid, data_byte, done_res,
		       status, bytes_done,
		input  ready
	);
	modport sink (
		input  valid, bus_action, tx_byte, data_valid, data_byte, done_res,
		       status, bytes_done,
		output ready
	);
endinterface

@@ rtl/i2cms_in_stage.sv @@
// Input register: captures one request word and holds it until the core takes it.
// Depends on i2cms_pkg and i2cms_req_if.

module i2cms_in_stage
	import i2cms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	i2cms_req_if.sink        req,
	input  logic             advance,
	output logic             valid_s1,
	output req_t             item_s1
);

	// Accept when empty or when the held word moves on this cycle
	assign req.ready = !valid_s1 || advance;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Load payload on acceptance
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type    <= req.req_type;
			item_s1.slave_addr  <= req.slave_addr;
			item_s1.reg_addr    <= req.reg_addr;
			item_s1.byte_count  <= req.byte_count;
			item_s1.write_value <= req.write_value;
			item_s1.bus_busy    <= req.bus_busy;
			item_s1.nack_seen   <= req.nack_seen;
			item_s1.arb_lost    <= req.arb_lost;
			item_s1.rx_byte     <= req.rx_byte;
		end
	end

endmodule

@@ rtl/i2cms_core.sv @@
// Transaction state machine, configuration registers and per-event result logic.
// Depends on i2cms_pkg.

module i2cms_core
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_data,
	input  logic       fire,
	input  req_t       item,
	output res_t       result
);

	logic [7:0]  timeout_ms_q, busy_retry_q;
	phase_t      phase_q, phase_d;
	logic        is_read_q, is_read_d;
	logic [7:0]  retry_q, retry_d;
	logic [7:0]  wait_q, wait_d;
	logic [6:0]  target_q, target_d;
	logic [7:0]  pointer_q, pointer_d;
	logic [15:0] value_q, value_d;
	logic [7:0]  remaining_q, remaining_d;
	logic [7:0]  received_q, received_d;
	logic        pending;
	logic [7:0]  cnt;
	logic [7:0]  wait_inc;
	logic [7:0]  rem_dec;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ms_q <= TIMEOUT_MS_RST;
			busy_retry_q <= BUSY_RETRY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TIMEOUT_MS: timeout_ms_q <= cfg_data;
				CFG_BUSY_RETRY: busy_retry_q <= cfg_data;
			endcase
		end
	end

	assign pending = (phase_q == PH_RADDR) || (phase_q == PH_RPTR) ||
	                 (phase_q == PH_RREAD) || (phase_q == PH_RDATA) ||
	                 (phase_q == PH_WADDR) || (phase_q == PH_WREG) ||
	                 (phase_q == PH_WHI) || (phase_q == PH_WLO);

	assign cnt = (32'(item.byte_count) > MAX_BURST) ? 8'(MAX_BURST) : item.byte_count;
	assign wait_inc = (wait_q != 8'hFF) ? wait_q + 8'd1 : wait_q;
	assign rem_dec = remaining_q - 8'd1;

	// Next state and result of the event
	always_comb begin
		phase_d     = phase_q;
		is_read_d   = is_read_q;
		retry_d     = retry_q;
		wait_d      = wait_q;
		target_d    = target_q;
		pointer_d   = pointer_q;
		value_d     = value_q;
		remaining_d = remaining_q;
		received_d  = received_q;
		result      = '0;
		result.bus_action = ACT_NONE;
		result.status     = ST_OK;

		if ((item.req_type == REQ_READ || item.req_type == REQ_WRITE) &&
		    phase_q == PH_IDLE) begin
			is_read_d   = (item.req_type == REQ_READ);
			target_d    = item.slave_addr;
			pointer_d   = item.reg_addr;
			value_d     = item.write_value;
			remaining_d = (item.req_type == REQ_READ) ? cnt : 8'd0;
			received_d  = 8'd0;
			retry_d     = busy_retry_q;
			wait_d      = 8'd0;
			phase_d     = PH_BUSY;
		end else if (item.req_type == REQ_BUSY && phase_q == PH_BUSY) begin
			if (item.bus_busy) begin
				if (retry_q <= 8'd1) begin
					retry_d         = 8'd0;
					result.done_res = 1'b1;
					result.status   = ST_BUSY;
					phase_d         = PH_IDLE;
				end else begin
					retry_d = retry_q - 8'd1;
				end
			end else begin
				result.bus_action = ACT_START;
				result.tx_byte    = {target_q, 1'b0};
				wait_d            = 8'd0;
				phase_d           = is_read_q ? PH_RADDR : PH_WADDR;
			end
		end else if (item.req_type == REQ_MS_TICK && pending) begin
			wait_d = wait_inc;
			if (wait_inc >= timeout_ms_q) begin
				result.bus_action = ACT_STOP;
				result.done_res   = 1'b1;
				result.status     = ST_TMO;
				phase_d           = PH_IDLE;
			end
		end else if (item.req_type == REQ_BYTE_DN && pending) begin
			// Stop with no-acknowledge by default; arms below override
			result.bus_action = ACT_STOP;
			result.done_res   = 1'b1;
			result.status     = ST_NACK;
			phase_d           = PH_IDLE;
			unique case (phase_q)
				PH_RADDR: begin
					if (item.arb_lost) begin
						result.status = ST_ARB;
					end else if (!item.nack_seen) begin
						result = '0;
						result.bus_action = ACT_SEND;
						result.status     = ST_OK;
						result.tx_byte    = pointer_q;
						wait_d            = 8'd0;
						phase_d           = PH_RPTR;
					end
				end
				PH_RPTR: begin
					if (!item.nack_seen) begin
						result = '0;
						result.bus_action = ACT_RESTART;
						result.status     = ST_OK;
						result.tx_byte    = {target_q, 1'b1};
						wait_d            = 8'd0;
						phase_d           = PH_RREAD;
					end
				end
				PH_RREAD: begin
					if (!item.nack_seen) begin
						if (remaining_q == 8'd0) begin
							// Empty burst ends without a stop
							result.bus_action = ACT_NONE;
							result.status     = ST_OK;
						end else begin
							result = '0;
							result.bus_action = (remaining_q == 8'd1) ? ACT_RXNACK : ACT_RXACK;
							result.status     = ST_OK;
							wait_d            = 8'd0;
							phase_d           = PH_RDATA;
						end
					end
				end
				PH_RDATA: begin
					// Deliver the byte; link status is ignored here
					received_d  = received_q + 8'd1;
					remaining_d = rem_dec;
					result.data_valid = 1'b1;
					result.data_byte  = item.rx_byte;
					result.status     = ST_OK;
					if (rem_dec != 8'd0) begin
						result.bus_action = (rem_dec == 8'd1) ? ACT_RXNACK : ACT_RXACK;
						result.done_res   = 1'b0;
						wait_d            = 8'd0;
						phase_d           = PH_RDATA;
					end
				end
				PH_WADDR: begin
					if (!item.nack_seen) begin
						result = '0;
						result.bus_action = ACT_SEND;
						result.status     = ST_OK;
						result.tx_byte    = pointer_q;
						wait_d            = 8'd0;
						phase_d           = PH_WREG;
					end
				end
				PH_WREG: begin
					if (!item.nack_seen) begin
						result = '0;
						result.bus_action = ACT_SEND;
						result.status     = ST_OK;
						result.tx_byte    = value_q[15:8];
						wait_d            = 8'd0;
						phase_d           = PH_WHI;
					end
				end
				PH_WHI: begin
					if (!item.nack_seen) begin
						result = '0;
						result.bus_action = ACT_SEND;
						result.status     = ST_OK;
						result.tx_byte    = value_q[7:0];
						wait_d            = 8'd0;
						phase_d           = PH_WLO;
					end
				end
				PH_WLO: begin
					if (!item.nack_seen) begin
						result.status = ST_OK;
					end
				end
				default: begin
					result  = '0;
					result.bus_action = ACT_NONE;
					result.status     = ST_OK;
					phase_d = phase_q;
				end
			endcase
		end

		result.bytes_done = received_d;
	end

	// Advance state on each event taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			is_read_q   <= 1'b0;
			retry_q     <= 8'd0;
			wait_q      <= 8'd0;
			target_q    <= 7'd0;
			pointer_q   <= 8'd0;
			value_q     <= 16'd0;
			remaining_q <= 8'd0;
			received_q  <= 8'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			is_read_q   <= is_read_d;
			retry_q     <= retry_d;
			wait_q      <= wait_d;
			target_q    <= target_d;
			pointer_q   <= pointer_d;
			value_q     <= value_d;
			remaining_q <= remaining_d;
			received_q  <= received_d;
		end
	end

endmodule

@@ rtl/i2cms_out_stage.sv @@
// Result register: holds one result word until the consumer takes it.
// Depends on i2cms_pkg and i2cms_res_if.

module i2cms_out_stage
	import i2cms_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  res_t         data,
	output logic         free,
	i2cms_res_if.source  res
);

	logic valid_q;
	res_t data_q;

	// Room for a new word when empty or when the held one leaves now
	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= data;
		end
	end

	assign res.valid      = valid_q;
	assign res.bus_action = data_q.bus_action;
	assign res.tx_byte    = data_q.tx_byte;
	assign res.data_valid = data_q.data_valid;
	assign res.data_byte  = data_q.data_byte;
	assign res.done_res   = data_q.done_res;
	assign res.status     = data_q.status;
	assign res.bytes_done = data_q.bytes_done;

endmodule

@@ rtl/i2c_master_register_sequencer.sv @@
// Top level of the I2C master register sequencer: input register, core, result register.
// Depends on i2cms_pkg, i2cms_if, i2cms_in_stage, i2cms_core and i2cms_out_stage.
//
//   port   direction  handshake     contents
//   req    sink       valid/ready   one bus event or request word
//   res    source     valid/ready   one result word per request word
//   cfg_*  input      cfg_we        register index and 8-bit data
//
// Flow: one word per clock sustained while res is ready; a taken request word
// passes through the input register, then the result register, before its result leaves.
// The core computes its result and state update from the word in the input register.
// Reset: arst_n clears control state and loads timeout 5 ms, retry limit 100.
// Stalls: a held result blocks the core; the input register keeps accepting
// until it holds a word of its own.

module i2c_master_register_sequencer
	import i2cms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2cms_req_if.sink   req,
	i2cms_res_if.source res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [7:0]  cfg_data
);

	logic valid_s1;
	req_t item_s1;
	logic out_free;
	logic advance;
	res_t result;

	// Move the held word through the core when the result register has room
	assign advance = valid_s1 && out_free;

	i2cms_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cms_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.fire     (advance),
		.item     (item_s1),
		.result   (result)
	);

	i2cms_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.data   (result),
		.free   (out_free),
		.res    (res)
	);

`ifndef NO_ASSERTIONS
	// An error status only comes with a finished transaction
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_OK |-> res.done_res)
		else $error("error status without done");

	// A delivered byte comes with a receive or a stop action
	a_data_act: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data_valid |->
		(res.bus_action == ACT_RXACK || res.bus_action == ACT_RXNACK ||
		 res.bus_action == ACT_STOP))
		else $error("data byte with wrong action");

	// Giving up on a busy bus never drives the bus
	a_busy_none: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res && res.status == ST_BUSY |->
		res.bus_action == ACT_NONE)
		else $error("bus busy completion with action");

	// The core only consumes a word that the input register holds
	a_adv_held: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1 && out_free)
		else $error("advance without held word");
`endif

endmodule
